// File: design/mep_pkg.sv
// Package for the Mandelbrot escape-time pixel block.
// Holds the fixed-point constants, register indexes, color band codes, item types
// and the saturation helper. It depends on nothing else.
package mep_pkg;

	// Sizing constants.
	localparam int unsigned COORD_BITS = 10;
	localparam int unsigned FRAC_BITS  = 28;
	localparam int unsigned COUNT_BITS = 16;

	// Only the low COORD_BITS bits of a coordinate take part.
	localparam int unsigned COORD_MASK = (1 << COORD_BITS) - 1;
	// Largest count the iteration counter can hold.
	localparam logic [31:0] COUNT_MAX  = 32'((64'd1 << COUNT_BITS) - 64'd1);
	// Escape bound: |z|^2 > 4 in the scale of a product of two fixed-point values.
	localparam logic [63:0] ESC_BOUND  = 64'd4 << (2 * FRAC_BITS);

	// Configuration register indexes.
	localparam logic [2:0] REG_REAL_ORIGIN = 3'd0;
	localparam logic [2:0] REG_IMAG_ORIGIN = 3'd1;
	localparam logic [2:0] REG_REAL_STEP   = 3'd2;
	localparam logic [2:0] REG_IMAG_STEP   = 3'd3;
	localparam logic [2:0] REG_ITER_LIMIT  = 3'd4;

	// Color band codes and the counts at which a band begins.
	localparam logic [2:0] BAND_RED    = 3'd0;
	localparam logic [2:0] BAND_BLUE   = 3'd1;
	localparam logic [2:0] BAND_YELLOW = 3'd2;
	localparam logic [2:0] BAND_GREEN  = 3'd3;
	localparam logic [2:0] BAND_BLACK  = 3'd4;
	localparam logic [31:0] EDGE_BLUE   = 32'd250;
	localparam logic [31:0] EDGE_YELLOW = 32'd500;
	localparam logic [31:0] EDGE_GREEN  = 32'd750;

	typedef struct packed {
		logic [9:0] column;
		logic [9:0] row;
	} in_item_t;

	typedef struct packed {
		logic [9:0]  out_column;
		logic [9:0]  out_row;
		logic [15:0] escape_count;
		logic [2:0]  colour_band;
	} out_item_t;

	// Three operand pairs for the shared multiplier set.
	typedef struct packed {
		logic signed [31:0] a0;
		logic signed [31:0] b0;
		logic signed [31:0] a1;
		logic signed [31:0] b1;
		logic signed [31:0] a2;
		logic signed [31:0] b2;
	} mul_ops_t;

	// Clamp a wide signed value into the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = signed'(v[31:0]);
		end
		return r;
	endfunction

endpackage

// File: design/mandelbrot_escape_time_pixel.sv
// Top level of the Mandelbrot escape-time pixel block: configuration registers,
// sequencer, z update and output register. Depends on mep_pkg and mep_mul_unit.
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   in_item  (column, row)
// out       output     out_valid / out_stall out_item (column, row, count, band)
// cfg       input      cfg_we                cfg_index, cfg_data
//
// A pixel accepted from the in channel is mapped to c in ST_CMUL (coordinate
// times step in the shared multiplier set) and ST_CADD (origin plus offset);
// then each iteration passes through ST_ZMUL, in the shared multiplier set,
// and ST_ZUPD, the add, compare and saturate step. A pixel at the limit
// makes one more ST_ZMUL pass for the limit check, an escaping pixel one more
// ST_ZMUL pass and one more compare in ST_ZUPD on the failing test, and
// ST_DONE decides the color band and loads the result.
// The block takes one pixel at a time; in_stall is high from acceptance until the
// result has moved into the output register. A waiting result does not keep the
// next pixel out, but a finished pixel holds the sequencer while out_stall keeps
// the output register full. Reset (arst_n low) restores the default view and an
// iteration limit of 1000 and empties the block.
module mandelbrot_escape_time_pixel
	import mep_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item,
	input  logic      cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a pixel
	localparam logic [2:0] ST_CMUL  = 3'd1;  // coordinate times step in the multipliers
	localparam logic [2:0] ST_CADD  = 3'd2;  // origin plus offset gives c
	localparam logic [2:0] ST_ZMUL  = 3'd3;  // limit check, squares and cross product
	localparam logic [2:0] ST_ZUPD  = 3'd4;  // escape test and z update
	localparam logic [2:0] ST_DONE  = 3'd5;  // band select and hand-off

	logic [2:0] state_q;

	// Configuration registers.
	logic signed [31:0] real_origin_q;
	logic signed [31:0] imag_origin_q;
	logic [30:0]        real_step_q;
	logic [30:0]        imag_step_q;
	logic [15:0]        iter_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_origin_q <= -32'sd536870912;
			imag_origin_q <= -32'sd402653184;
			real_step_q   <= 31'd1006633;
			imag_step_q   <= 31'd1006633;
			iter_limit_q  <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REAL_ORIGIN: real_origin_q <= signed'(cfg_data);
				REG_IMAG_ORIGIN: imag_origin_q <= signed'(cfg_data);
				REG_REAL_STEP:   real_step_q   <= cfg_data[30:0];
				REG_IMAG_STEP:   imag_step_q   <= cfg_data[30:0];
				REG_ITER_LIMIT:  iter_limit_q  <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Working registers of the pixel in flight.
	logic [9:0]            col_q;
	logic [9:0]            row_q;
	logic [COUNT_BITS-1:0] limit_q;
	logic [COUNT_BITS-1:0] count_q;
	logic signed [31:0]    cr_q;
	logic signed [31:0]    ci_q;
	logic signed [31:0]    zr_q;
	logic signed [31:0]    zi_q;

	logic      out_valid_q;
	out_item_t out_item_q;

	// The limit is capped to what the counter can hold.
	logic [31:0] limit_wide;
	logic [31:0] limit_capped;
	assign limit_wide   = {16'd0, iter_limit_q};
	assign limit_capped = (limit_wide > COUNT_MAX) ? COUNT_MAX : limit_wide;

	logic accept;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Operand selection for the shared multiplier set. While mapping the pixel
	// the first two pairs give column*real_step and row*imag_step; during the
	// iteration they give zr*zr, zi*zi and zr*zi.
	mul_ops_t           ops;
	logic signed [63:0] p0;
	logic signed [63:0] p1;
	logic signed [63:0] p2;

	always_comb begin
		if (state_q == ST_CMUL) begin
			ops.a0 = signed'({22'd0, col_q});
			ops.b0 = signed'({1'b0, real_step_q});
			ops.a1 = signed'({22'd0, row_q});
			ops.b1 = signed'({1'b0, imag_step_q});
			ops.a2 = zr_q;
			ops.b2 = zi_q;
		end else begin
			ops.a0 = zr_q;
			ops.b0 = zr_q;
			ops.a1 = zi_q;
			ops.b1 = zi_q;
			ops.a2 = zr_q;
			ops.b2 = zi_q;
		end
	end

	mep_mul_unit u_mul (
		.clk (clk),
		.ops (ops),
		.p0  (p0),
		.p1  (p1),
		.p2  (p2)
	);

	// Point c: origin plus the registered offset, saturated.
	logic signed [31:0] cr_next;
	logic signed [31:0] ci_next;
	assign cr_next = sat32(64'(real_origin_q) + p0);
	assign ci_next = sat32(64'(imag_origin_q) + p1);

	// Escape test and z update. Each square is at most 2^62, so the unsigned sum
	// cannot wrap. The arithmetic shifts round towards minus infinity.
	logic [63:0]        mag2;
	logic               escaped;
	logic signed [63:0] rdiff;
	logic signed [31:0] zr_next;
	logic signed [31:0] zi_next;
	assign mag2    = $unsigned(p0) + $unsigned(p1);
	assign escaped = mag2 > ESC_BOUND;
	assign rdiff   = p0 - p1;
	assign zr_next = sat32((rdiff >>> FRAC_BITS) + 64'(cr_q));
	assign zi_next = sat32((p2 >>> (FRAC_BITS - 1)) + 64'(ci_q));

	// Color band of the finished count; the limit takes precedence.
	logic [31:0] count_wide;
	logic [2:0]  band;
	assign count_wide = 32'(count_q);

	always_comb begin
		if (count_q == limit_q) begin
			band = BAND_BLACK;
		end else if (count_wide < EDGE_BLUE) begin
			band = BAND_RED;
		end else if (count_wide < EDGE_YELLOW) begin
			band = BAND_BLUE;
		end else if (count_wide < EDGE_GREEN) begin
			band = BAND_YELLOW;
		end else begin
			band = BAND_GREEN;
		end
	end

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CMUL;
					end
				end
				ST_CMUL: state_q <= ST_CADD;
				ST_CADD: state_q <= ST_ZMUL;
				ST_ZMUL: begin
					if (count_q == limit_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_ZUPD;
					end
				end
				ST_ZUPD: begin
					if (escaped) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_ZMUL;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the pixel in flight.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					col_q   <= in_item.column & 10'(COORD_MASK);
					row_q   <= in_item.row & 10'(COORD_MASK);
					limit_q <= limit_capped[COUNT_BITS-1:0];
				end
			end
			ST_CADD: begin
				cr_q    <= cr_next;
				ci_q    <= ci_next;
				zr_q    <= '0;
				zi_q    <= '0;
				count_q <= '0;
			end
			ST_ZUPD: begin
				if (!escaped) begin
					zr_q    <= zr_next;
					zi_q    <= zi_next;
					count_q <= count_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: loaded when the pixel is done and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_item_q.out_column   <= col_q;
			out_item_q.out_row      <= row_q;
			out_item_q.escape_count <= count_wide[15:0];
			out_item_q.colour_band  <= band;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// File: design/mep_mul_unit.sv
// Shared multiplier set of the Mandelbrot pixel block: three signed 32x32 products,
// registered. Depends on mep_pkg for the operand type.
module mep_mul_unit
	import mep_pkg::*;
(
	input  logic               clk,
	input  mul_ops_t           ops,
	output logic signed [63:0] p0,
	output logic signed [63:0] p1,
	output logic signed [63:0] p2
);

	// Products land in the cycle after the operands are presented.
	always_ff @(posedge clk) begin
		p0 <= 64'(ops.a0) * 64'(ops.b0);
		p1 <= 64'(ops.a1) * 64'(ops.b1);
		p2 <= 64'(ops.a2) * 64'(ops.b2);
	end

endmodule
